// ===== rtl/depth_pixel_backprojection_macros.svh =====
// Assertion macros used by the depth pixel back-projection top level.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define DPB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DPB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/dpb_pkg.sv =====
// Shared types and constants of the depth pixel back-projection pipeline.
package dpb_pkg;

	// Pipeline shape: four stages of back-projection, seven of transform and scaling
	localparam int LAT_STAGES = 4;
	localparam int NUM_STAGES = 11;

	// Signed camera coordinate, units of 2^-16 mm
	localparam int CAM_W = 45;

	// One enable bit per pipeline stage
	typedef logic [NUM_STAGES-1:0] stage_en_t;

	// Configuration register indexes
	localparam logic [2:0] REG_INV_FOCAL   = 3'd0;
	localparam logic [2:0] REG_PRINCIPAL   = 3'd1;
	localparam logic [2:0] REG_TRANSFORM_X = 3'd2;
	localparam logic [2:0] REG_TRANSFORM_Y = 3'd3;
	localparam logic [2:0] REG_TRANSFORM_Z = 3'd4;

	// Register reset values: identity rotation in Q2.13, no translation
	localparam logic [63:0] INV_FOCAL_RST   = 64'h0;
	localparam logic [31:0] PRINCIPAL_RST   = 32'h0;
	localparam logic [63:0] TRANSFORM_X_RST = 64'h2000_0000_0000_0000;
	localparam logic [63:0] TRANSFORM_Y_RST = 64'h0000_2000_0000_0000;
	localparam logic [63:0] TRANSFORM_Z_RST = 64'h0000_0000_2000_0000;

	// Millimetre to micrometre scale
	localparam logic [9:0] MM_TO_UM = 10'd1000;

endpackage

// ===== rtl/dpb_lateral.sv =====
// Back-projection of one lateral axis: (16*coord - center) * depth * inv_focal.
module dpb_lateral import dpb_pkg::*; (
	input  logic                    clk,
	input  stage_en_t               stage_en,
	input  logic [11:0]             coord,
	input  logic [15:0]             center,
	input  logic [15:0]             depth,
	input  logic [31:0]             inv_focal,
	output logic signed [CAM_W-1:0] cam
);

	logic signed [16:0] diff;
	logic [16:0]        diff_abs;
	logic [64:0]        rounded;

	logic        neg_s1;
	logic [15:0] off_s1;
	logic [15:0] depth_s1;
	logic        neg_s2;
	logic [31:0] mag_s2;
	logic        neg_s3;
	logic [63:0] prod_s3;
	logic signed [CAM_W-1:0] cam_s4;

	// Signed offset from the principal point in Q.4 pixels
	assign diff     = signed'({1'b0, coord, 4'b0000}) - signed'({1'b0, center});
	assign diff_abs = diff[16] ? (17'd0 - 17'(diff)) : 17'(diff);
	assign rounded  = 65'(prod_s3) + 65'(64'd1 << 19);

	always_ff @(posedge clk) begin
		// Stage 1: split offset into sign and magnitude
		if (stage_en[0]) begin
			neg_s1   <= diff[16];
			off_s1   <= diff_abs[15:0];
			depth_s1 <= depth;
		end
		// Stage 2: scale by depth
		if (stage_en[1]) begin
			neg_s2 <= neg_s1;
			mag_s2 <= 32'(off_s1) * 32'(depth_s1);
		end
		// Stage 3: scale by reciprocal focal length
		if (stage_en[2]) begin
			neg_s3  <= neg_s2;
			prod_s3 <= 64'(mag_s2) * 64'(inv_focal);
		end
		// Stage 4: round the magnitude half up, then restore the sign
		if (stage_en[3]) begin
			cam_s4 <= neg_s3 ? -signed'(CAM_W'(rounded[63:20]))
			                 : signed'(CAM_W'(rounded[63:20]));
		end
	end

	assign cam = cam_s4;

endmodule

// ===== rtl/dpb_row.sv =====
// One row of the world transform, scaled to micrometres and saturated to 32 bits.
module dpb_row import dpb_pkg::*; (
	input  logic                    clk,
	input  stage_en_t               stage_en,
	input  logic [63:0]             row_cfg,
	input  logic signed [CAM_W-1:0] cam_x,
	input  logic signed [CAM_W-1:0] cam_y,
	input  logic [15:0]             depth,
	output logic signed [31:0]      world_um
);

	logic signed [15:0] rot0;
	logic signed [15:0] rot1;
	logic signed [15:0] rot2;
	logic signed [15:0] trans;
	logic signed [32:0] cam_z;
	logic [38:0]        lo_scaled;

	logic signed [60:0] px_s5;
	logic signed [60:0] py_s5;
	logic signed [48:0] pz_s5;
	logic signed [15:0] t_s5;
	logic signed [61:0] sum_a_s6;
	logic signed [49:0] sum_b_s6;
	logic signed [63:0] acc_s7;
	logic               neg_s8;
	logic [63:0]        mag_s8;
	logic               neg_s9;
	logic [44:0]        hi_s9;
	logic [10:0]        lo_s9;
	logic               neg_s10;
	logic [45:0]        um_s10;
	logic signed [31:0] out_s11;

	assign rot0  = signed'(row_cfg[63:48]);
	assign rot1  = signed'(row_cfg[47:32]);
	assign rot2  = signed'(row_cfg[31:16]);
	assign trans = signed'(row_cfg[15:0]);
	assign cam_z = signed'({1'b0, depth, 16'h0000});

	// Fraction below one millimetre, scaled and rounded half up
	assign lo_scaled = 39'(mag_s8[28:0]) * 39'(MM_TO_UM) + 39'(39'd1 << 28);

	always_ff @(posedge clk) begin
		// Stage 5: rotation products
		if (stage_en[4]) begin
			px_s5 <= 61'(rot0) * 61'(cam_x);
			py_s5 <= 61'(rot1) * 61'(cam_y);
			pz_s5 <= 49'(rot2) * 49'(cam_z);
			t_s5  <= trans;
		end
		// Stage 6: partial sums, translation in 2^-29 mm
		if (stage_en[5]) begin
			sum_a_s6 <= 62'(px_s5) + 62'(py_s5);
			sum_b_s6 <= 50'(pz_s5) + (50'(t_s5) <<< 29);
		end
		// Stage 7: full accumulation
		if (stage_en[6]) begin
			acc_s7 <= 64'(sum_a_s6) + 64'(sum_b_s6);
		end
		// Stage 8: sign and magnitude
		if (stage_en[7]) begin
			neg_s8 <= acc_s7[63];
			mag_s8 <= acc_s7[63] ? (64'd0 - 64'(acc_s7)) : 64'(acc_s7);
		end
		// Stage 9: scale whole and fractional millimetres
		if (stage_en[8]) begin
			neg_s9 <= neg_s8;
			hi_s9  <= 45'(mag_s8[63:29]) * 45'(MM_TO_UM);
			lo_s9  <= 11'(lo_scaled >> 29);
		end
		// Stage 10: combine
		if (stage_en[9]) begin
			neg_s10 <= neg_s9;
			um_s10  <= 46'(hi_s9) + 46'(lo_s9);
		end
		// Stage 11: saturate and restore the sign
		if (stage_en[10]) begin
			if (neg_s10) begin
				out_s11 <= (um_s10 > 46'h0_8000_0000) ? 32'sh8000_0000
				                                      : signed'(32'd0 - um_s10[31:0]);
			end else begin
				out_s11 <= (um_s10 > 46'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
				                                      : signed'(um_s10[31:0]);
			end
		end
	end

	assign world_um = out_s11;

endmodule

// ===== rtl/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection pipeline.
// Depth pixel back-projection: each transaction on the input is one depth pixel; the block
// back-projects it through the pinhole intrinsics, applies one rigid 3x4 world transform
// (Q2.13 rotation, translation in mm) and returns the point in micrometres, saturated to
// 32 bits, with the color passed through. A zero depth yields point_valid = 0 and a zero
// position. The pipeline has 11 register stages and takes one pixel per clock whenever the
// output is not stalled. The stage count is set by the multiplier chain of the reciprocal
// focal scaling (16x16 then 32x32) and the transform and micrometre scaling that follow.
// Internal bubbles are absorbed, so the input stalls only when every stage holds a point.
// Write the configuration registers only while the pipeline is empty.
`include "depth_pixel_backprojection_macros.svh"

module depth_pixel_backprojection import dpb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	// Pixel input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        pixel_col,
	input  logic [11:0]        pixel_row,
	input  logic [15:0]        depth_mm,
	input  logic [31:0]        pixel_color,
	// Point output
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] world_x_um,
	output logic signed [31:0] world_y_um,
	output logic signed [31:0] world_z_um,
	output logic [31:0]        point_color,
	output logic               point_valid
);

	logic [63:0] inv_focal_q;
	logic [31:0] principal_q;
	logic [63:0] transform_x_q;
	logic [63:0] transform_y_q;
	logic [63:0] transform_z_q;

	stage_en_t               stage_en;
	logic [NUM_STAGES-1:0]   vld_s;
	logic [NUM_STAGES-1:0]   nz_s;
	logic [31:0]             color_s [NUM_STAGES];
	logic [15:0]             depth_s [LAT_STAGES];
	logic signed [CAM_W-1:0] cam_x;
	logic signed [CAM_W-1:0] cam_y;
	logic signed [31:0]      wx;
	logic signed [31:0]      wy;
	logic signed [31:0]      wz;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_q   <= INV_FOCAL_RST;
			principal_q   <= PRINCIPAL_RST;
			transform_x_q <= TRANSFORM_X_RST;
			transform_y_q <= TRANSFORM_Y_RST;
			transform_z_q <= TRANSFORM_Z_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_INV_FOCAL:   inv_focal_q   <= cfg_data;
				REG_PRINCIPAL:   principal_q   <= cfg_data[31:0];
				REG_TRANSFORM_X: transform_x_q <= cfg_data;
				REG_TRANSFORM_Y: transform_y_q <= cfg_data;
				REG_TRANSFORM_Z: transform_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage enables: a stage advances when empty or when the stage after it advances
	always_comb begin
		stage_en[NUM_STAGES-1] = !vld_s[NUM_STAGES-1] || !out_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !vld_s[k] || stage_en[k+1];
		end
	end

	assign in_stall = !stage_en[0];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Side payload: color, nonzero-depth flag and depth for the z coordinate
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			color_s[0] <= pixel_color;
			nz_s[0]    <= (depth_mm != 16'd0);
			depth_s[0] <= depth_mm;
		end
		for (int k = 1; k < NUM_STAGES; k++) begin
			if (stage_en[k]) begin
				color_s[k] <= color_s[k-1];
				nz_s[k]    <= nz_s[k-1];
			end
		end
		for (int k = 1; k < LAT_STAGES; k++) begin
			if (stage_en[k]) begin
				depth_s[k] <= depth_s[k-1];
			end
		end
	end

	// Back-projection of both lateral axes
	dpb_lateral u_lat_x (
		.clk       (clk),
		.stage_en  (stage_en),
		.coord     (pixel_col),
		.center    (principal_q[31:16]),
		.depth     (depth_mm),
		.inv_focal (inv_focal_q[63:32]),
		.cam       (cam_x)
	);

	dpb_lateral u_lat_y (
		.clk       (clk),
		.stage_en  (stage_en),
		.coord     (pixel_row),
		.center    (principal_q[15:0]),
		.depth     (depth_mm),
		.inv_focal (inv_focal_q[31:0]),
		.cam       (cam_y)
	);

	// World transform, one row per axis
	dpb_row u_row_x (
		.clk      (clk),
		.stage_en (stage_en),
		.row_cfg  (transform_x_q),
		.cam_x    (cam_x),
		.cam_y    (cam_y),
		.depth    (depth_s[LAT_STAGES-1]),
		.world_um (wx)
	);

	dpb_row u_row_y (
		.clk      (clk),
		.stage_en (stage_en),
		.row_cfg  (transform_y_q),
		.cam_x    (cam_x),
		.cam_y    (cam_y),
		.depth    (depth_s[LAT_STAGES-1]),
		.world_um (wy)
	);

	dpb_row u_row_z (
		.clk      (clk),
		.stage_en (stage_en),
		.row_cfg  (transform_z_q),
		.cam_x    (cam_x),
		.cam_y    (cam_y),
		.depth    (depth_s[LAT_STAGES-1]),
		.world_um (wz)
	);

	// Drop the position of zero-depth points
	assign out_valid   = vld_s[NUM_STAGES-1];
	assign point_valid = nz_s[NUM_STAGES-1];
	assign point_color = color_s[NUM_STAGES-1];
	assign world_x_um  = nz_s[NUM_STAGES-1] ? wx : 32'sd0;
	assign world_y_um  = nz_s[NUM_STAGES-1] ? wy : 32'sd0;
	assign world_z_um  = nz_s[NUM_STAGES-1] ? wz : 32'sd0;

	// Input stalls only when every stage is occupied
	`DPB_ASSERT_IMPL(a_stall_only_full, clk, arst_n, in_stall, (&vld_s), "input stalled with a free stage")
	// Zero-depth points carry a zero position
	`DPB_ASSERT_IMPL(a_invalid_zero, clk, arst_n, out_valid && !point_valid, (world_x_um == 32'sd0) && (world_y_um == 32'sd0) && (world_z_um == 32'sd0), "invalid point with nonzero position")
	// An accepted pixel with nothing leaving raises the occupancy by one
	`DPB_ASSERT_NEXT(a_occupancy, clk, arst_n, in_valid && !in_stall && !(out_valid && !out_stall), $countones(vld_s) == $past($countones(vld_s)) + 1, "pipeline lost or duplicated a transaction")
	// Writes beyond the last register leave the configuration unchanged
	`DPB_ASSERT_NEXT(a_cfg_ignore, clk, arst_n, cfg_wr_en && (cfg_index > REG_TRANSFORM_Z), $stable(inv_focal_q) && $stable(principal_q) && $stable(transform_x_q) && $stable(transform_y_q) && $stable(transform_z_q), "write beyond the register list took effect")

endmodule
